### rtl/core/uart_rb_pkg.sv
// Shared types, register offsets, bit positions and the status reset value for the USART register block.
package uart_rb_pkg;

	// register byte offsets
	localparam logic [7:0] OFF_STATUS  = 8'd0;
	localparam logic [7:0] OFF_DATA    = 8'd4;
	localparam logic [7:0] OFF_BAUD    = 8'd8;
	localparam logic [7:0] OFF_CTRL1   = 8'd12;
	localparam logic [7:0] OFF_CTRL2   = 8'd16;
	localparam logic [7:0] OFF_CTRL3   = 8'd20;
	localparam logic [7:0] OFF_GUARD   = 8'd24;

	// access kinds
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// status bits
	localparam int SR_RXNE = 5;
	localparam int SR_TXE  = 7;

	// control one bits
	localparam int C1_RE     = 2;
	localparam int C1_TE     = 3;
	localparam int C1_RXNEIE = 5;
	localparam int C1_TXEIE  = 7;
	localparam int C1_UE     = 13;

	localparam logic [9:0] STATUS_RESET = 10'h0C0;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  reg_offset;
		logic [31:0] write_data;
		logic        peer_has_data;
		logic [7:0]  peer_byte;
		logic        peer_has_more;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        peer_taken;
		logic        bad_access;
	} rsp_t;

endpackage

### rtl/core/uart_rb_regfile.sv
// Register state and single-pass access logic of the USART register block.
module uart_rb_regfile (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  uart_rb_pkg::req_t req,
	output uart_rb_pkg::rsp_t rsp
);

	logic [9:0]  status_q, status_d;
	logic [9:0]  data_q, data_d;
	logic [15:0] baud_q, baud_d;
	logic [13:0] ctrl1_q, ctrl1_d;
	logic [14:0] ctrl2_q, ctrl2_d;
	logic [10:0] ctrl3_q, ctrl3_d;
	logic [15:0] guard_q, guard_d;

	logic ue_te;
	logic ue_re;

	assign ue_te = ctrl1_q[uart_rb_pkg::C1_UE] & ctrl1_q[uart_rb_pkg::C1_TE];
	assign ue_re = ctrl1_q[uart_rb_pkg::C1_UE] & ctrl1_q[uart_rb_pkg::C1_RE];

	always_comb begin
		status_d = status_q;
		data_d   = data_q;
		baud_d   = baud_q;
		ctrl1_d  = ctrl1_q;
		ctrl2_d  = ctrl2_q;
		ctrl3_d  = ctrl3_q;
		guard_d  = guard_q;
		rsp      = '0;

		if (req.cmd == uart_rb_pkg::CMD_WRITE) begin
			case (req.reg_offset)
				uart_rb_pkg::OFF_STATUS: status_d = status_q & req.write_data[9:0];
				uart_rb_pkg::OFF_DATA: begin
					data_d = req.write_data[9:0];
					if (ue_te) begin
						rsp.tx_valid = 1'b1;
						rsp.tx_byte  = req.write_data[7:0];
						if (req.peer_has_data && ctrl1_q[uart_rb_pkg::C1_RE])
							status_d[uart_rb_pkg::SR_RXNE] = 1'b1;
					end
					status_d[uart_rb_pkg::SR_TXE] = 1'b1;
				end
				uart_rb_pkg::OFF_BAUD:  baud_d  = req.write_data[15:0];
				uart_rb_pkg::OFF_CTRL1: ctrl1_d = req.write_data[13:0];
				uart_rb_pkg::OFF_CTRL2: ctrl2_d = req.write_data[14:0];
				uart_rb_pkg::OFF_CTRL3: ctrl3_d = req.write_data[10:0];
				uart_rb_pkg::OFF_GUARD: guard_d = req.write_data[15:0];
				default: rsp.bad_access = 1'b1;
			endcase
			// irq from the post-write control and status values
			rsp.irq = ctrl1_d[uart_rb_pkg::C1_UE] & ctrl1_d[uart_rb_pkg::C1_TE] &
				((ctrl1_d[uart_rb_pkg::C1_TXEIE] & status_d[uart_rb_pkg::SR_TXE]) |
				 (ctrl1_d[uart_rb_pkg::C1_RE] & ctrl1_d[uart_rb_pkg::C1_RXNEIE] &
				  status_d[uart_rb_pkg::SR_RXNE]));
		end else begin
			case (req.reg_offset)
				uart_rb_pkg::OFF_STATUS: rsp.read_data = {6'b0, status_q};
				uart_rb_pkg::OFF_DATA: begin
					status_d[uart_rb_pkg::SR_RXNE] = 1'b0;
					if (ue_re) begin
						if (req.peer_has_data) begin
							data_d         = {2'b0, req.peer_byte};
							rsp.peer_taken = 1'b1;
							if (req.peer_has_more)
								status_d[uart_rb_pkg::SR_RXNE] = 1'b1;
						end
						rsp.irq = ctrl1_q[uart_rb_pkg::C1_RXNEIE] &
							status_d[uart_rb_pkg::SR_RXNE];
					end
					rsp.read_data = {6'b0, data_d};
				end
				uart_rb_pkg::OFF_BAUD:  rsp.read_data = baud_q;
				uart_rb_pkg::OFF_CTRL1: rsp.read_data = {2'b0, ctrl1_q};
				uart_rb_pkg::OFF_CTRL2: rsp.read_data = {1'b0, ctrl2_q};
				uart_rb_pkg::OFF_CTRL3: rsp.read_data = {5'b0, ctrl3_q};
				uart_rb_pkg::OFF_GUARD: rsp.read_data = guard_q;
				default: rsp.bad_access = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= uart_rb_pkg::STATUS_RESET;
			data_q   <= '0;
			baud_q   <= '0;
			ctrl1_q  <= '0;
			ctrl2_q  <= '0;
			ctrl3_q  <= '0;
			guard_q  <= '0;
		end else if (en) begin
			status_q <= status_d;
			data_q   <= data_d;
			baud_q   <= baud_d;
			ctrl1_q  <= ctrl1_d;
			ctrl2_q  <= ctrl2_d;
			ctrl3_q  <= ctrl3_d;
			guard_q  <= guard_d;
		end
	end

endmodule

### rtl/core/uart_register_block_core.sv
// Top level of the USART register block: input stage, register file, result register.
//
// channel | dir | tdata fields (low bit up)                              | tuser
// s_axis  | in  | reg_offset, write_data, peer_has_data, peer_byte,      | cmd
//         |     | peer_has_more, zero pad to 56 bits                      |
// m_axis  | out | read_data, irq, tx_valid, tx_byte, peer_taken,          | none
//         |     | bad_access, zero pad to 32 bits                         |
//
// One transaction per cycle sustained while m_axis does not stall. The input
// register feeds the register-file access logic, whose result and state
// update land in the same edge into the result register.
// Reset (arst_n low) clears both stage valids and returns the register-file
// registers to their reset values; status comes up with TXE and bit 6 set.
// A stall on m_axis holds the result register and the input stage; s_tready
// stays high as long as the input stage is empty or can move on.
module uart_register_block_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] reg_offset, [39:8] write_data, [40] peer_has_data,
	// [48:41] peer_byte, [49] peer_has_more, [55:50] zero
	input  logic [55:0] s_tdata,
	// [0] cmd
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] read_data, [16] irq, [17] tx_valid, [25:18] tx_byte,
	// [26] peer_taken, [27] bad_access, [31:28] zero
	output logic [31:0] m_tdata
);

	uart_rb_pkg::req_t req_s1;
	logic              valid_s1;
	uart_rb_pkg::rsp_t rsp;
	uart_rb_pkg::rsp_t rsp_q;
	logic              out_valid_q;
	logic              advance;

	// stage 1 moves into the result register when that register is free
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cmd           <= s_tuser;
			req_s1.reg_offset    <= s_tdata[7:0];
			req_s1.write_data    <= s_tdata[39:8];
			req_s1.peer_has_data <= s_tdata[40];
			req_s1.peer_byte     <= s_tdata[48:41];
			req_s1.peer_has_more <= s_tdata[49];
		end
	end

	// state commits only when the transaction leaves stage 1
	uart_rb_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= rsp;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, rsp_q.bad_access, rsp_q.peer_taken, rsp_q.tx_byte,
		rsp_q.tx_valid, rsp_q.irq, rsp_q.read_data};

endmodule

### rtl/core/uart_rb_checker.sv
// Port-level checker for the USART register block, bound to the top level.
module uart_rb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// no transmit byte without tx_valid
	a_txbyte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[17] |-> m_tdata[25:18] == 8'd0)
		else $error("tx_byte set without tx_valid");

	// a transmit only comes from a write: no read data, no peer load, good offset
	a_txwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[15:0] == 16'd0 && !m_tdata[26] && !m_tdata[27])
		else $error("transmit on a non-write access");

	// unknown offset reads zero and moves no data
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[27] |-> m_tdata[15:0] == 16'd0 && !m_tdata[26])
		else $error("bad access returned data");

endmodule

bind uart_register_block_core uart_rb_checker u_uart_rb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/uart_register_block_core_test.sv
// Self-checking testbench for the USART register block: bus accesses in, one response each out.
module uart_register_block_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ACCESSES = 850;
	localparam int CYCLE_LIMIT     = 300000;   // slowest legal run is far below this
	localparam int DRAIN_CYCLES    = 12;       // pipeline is two deep, leave margin

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	uart_register_block_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Accesses waiting to be offered; the head is what sits on s_axis while s_tvalid is high.
	uart_rb_pkg::req_t access_queue[$];
	// Responses the block owes us, oldest first.
	uart_rb_pkg::rsp_t responses_due[$];

	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_irq = 0;
	int unsigned n_tx = 0;
	int unsigned n_taken = 0;
	int unsigned n_bad = 0;

	// Shadow copy of the register file, kept at the block's own widths.
	logic [9:0]  sh_status = uart_rb_pkg::STATUS_RESET;
	logic [9:0]  sh_data   = '0;
	logic [15:0] sh_baud   = '0;
	logic [13:0] sh_ctrl1  = '0;
	logic [14:0] sh_ctrl2  = '0;
	logic [10:0] sh_ctrl3  = '0;
	logic [15:0] sh_guard  = '0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Applies one bus access to the shadow registers and returns the response the block
	// must produce for it.
	function automatic uart_rb_pkg::rsp_t usart_access(uart_rb_pkg::req_t a);
		uart_rb_pkg::rsp_t r;
		r = '0;
		if (a.cmd == uart_rb_pkg::CMD_WRITE) begin
			case (a.reg_offset)
				uart_rb_pkg::OFF_STATUS: sh_status = sh_status & a.write_data[9:0];
				uart_rb_pkg::OFF_DATA: begin
					sh_data = a.write_data[9:0];
					if (sh_ctrl1[uart_rb_pkg::C1_UE] && sh_ctrl1[uart_rb_pkg::C1_TE]) begin
						r.tx_valid = 1'b1;
						r.tx_byte  = sh_data[7:0];
						if (a.peer_has_data && sh_ctrl1[uart_rb_pkg::C1_RE])
							sh_status[uart_rb_pkg::SR_RXNE] = 1'b1;
					end
					sh_status[uart_rb_pkg::SR_TXE] = 1'b1;
				end
				uart_rb_pkg::OFF_BAUD:  sh_baud  = a.write_data[15:0];
				uart_rb_pkg::OFF_CTRL1: sh_ctrl1 = a.write_data[13:0];
				uart_rb_pkg::OFF_CTRL2: sh_ctrl2 = a.write_data[14:0];
				uart_rb_pkg::OFF_CTRL3: sh_ctrl3 = a.write_data[10:0];
				uart_rb_pkg::OFF_GUARD: sh_guard = a.write_data[15:0];
				default:   r.bad_access = 1'b1;
			endcase
			// every write, unknown offsets included, re-evaluates the request
			if (sh_ctrl1[uart_rb_pkg::C1_UE] && sh_ctrl1[uart_rb_pkg::C1_TE] &&
			    ((sh_ctrl1[uart_rb_pkg::C1_TXEIE] && sh_status[uart_rb_pkg::SR_TXE]) ||
			     (sh_ctrl1[uart_rb_pkg::C1_RE] && sh_ctrl1[uart_rb_pkg::C1_RXNEIE] &&
			      sh_status[uart_rb_pkg::SR_RXNE])))
				r.irq = 1'b1;
		end else begin
			case (a.reg_offset)
				uart_rb_pkg::OFF_STATUS: r.read_data = 16'(sh_status);
				uart_rb_pkg::OFF_DATA: begin
					sh_status[uart_rb_pkg::SR_RXNE] = 1'b0;
					if (sh_ctrl1[uart_rb_pkg::C1_UE] && sh_ctrl1[uart_rb_pkg::C1_RE]) begin
						if (a.peer_has_data) begin
							sh_data = 10'(a.peer_byte);
							r.peer_taken = 1'b1;
							if (a.peer_has_more)
								sh_status[uart_rb_pkg::SR_RXNE] = 1'b1;
						end
						if (sh_ctrl1[uart_rb_pkg::C1_RXNEIE] && sh_status[uart_rb_pkg::SR_RXNE])
							r.irq = 1'b1;
					end
					r.read_data = 16'(sh_data);
				end
				uart_rb_pkg::OFF_BAUD:  r.read_data = sh_baud;
				uart_rb_pkg::OFF_CTRL1: r.read_data = 16'(sh_ctrl1);
				uart_rb_pkg::OFF_CTRL2: r.read_data = 16'(sh_ctrl2);
				uart_rb_pkg::OFF_CTRL3: r.read_data = 16'(sh_ctrl3);
				uart_rb_pkg::OFF_GUARD: r.read_data = sh_guard;
				default:   r.bad_access = 1'b1;
			endcase
		end
		return r;
	endfunction

	task automatic queue_access(logic cmd, logic [7:0] off, logic [31:0] wdata,
	                            logic has_data, logic [7:0] pbyte, logic has_more);
		uart_rb_pkg::req_t a;
		a.cmd           = cmd;
		a.reg_offset    = off;
		a.write_data    = wdata;
		a.peer_has_data = has_data;
		a.peer_byte     = pbyte;
		a.peer_has_more = has_more;
		access_queue.insert(access_queue.size(), a);
	endtask

	task automatic report_mismatch(string field, int unsigned got, int unsigned want);
		mismatches++;
		$display("tb: response %0d field %s got 0x%0h want 0x%0h", n_checked, field, got, want);
	endtask

	// Random offset among the seven real registers.
	function automatic logic [7:0] any_register();
		return 8'(4 * $urandom_range(0, 6));
	endfunction

	// Random single bit.
	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// Driver: sends accesses in bursts of random length separated by random gaps. The
	// shadow registers are updated at the edge where the transaction is accepted, which
	// keeps predictions in bus order.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				responses_due.insert(responses_due.size(),
				                     usart_access(access_queue.pop_front()));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (access_queue.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					// pack low field first: offset, write data, peer flag, peer byte, more flag
					s_tdata  <= {6'b0, access_queue[0].peer_has_more, access_queue[0].peer_byte,
					             access_queue[0].peer_has_data, access_queue[0].write_data,
					             access_queue[0].reg_offset};
					s_tuser  <= access_queue[0].cmd;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					// about a third of bursts run straight into the next one
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Receiver: cycles through stall modes - always ready, coin flip, mostly stalled,
	// and a fixed on/off rhythm - each held for a random stretch.
	int stall_mode = 0;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(8, 64);
			end
			mode_left--;
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= coin();
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (cycles % 3) != 0;
			endcase
		end
	end

	// Monitor: every accepted response is checked field by field against the oldest one due.
	always @(posedge clk) begin : check_responses
		uart_rb_pkg::rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (responses_due.size() == 0) begin
				report_mismatch("unexpected", m_tdata, 32'd0);
			end else begin
				want = responses_due.pop_front();
				if (m_tdata[15:0] !== want.read_data)
					report_mismatch("read_data", 32'(m_tdata[15:0]), 32'(want.read_data));
				if (m_tdata[16] !== want.irq)
					report_mismatch("irq", 32'(m_tdata[16]), 32'(want.irq));
				if (m_tdata[17] !== want.tx_valid)
					report_mismatch("tx_valid", 32'(m_tdata[17]), 32'(want.tx_valid));
				if (m_tdata[25:18] !== want.tx_byte)
					report_mismatch("tx_byte", 32'(m_tdata[25:18]), 32'(want.tx_byte));
				if (m_tdata[26] !== want.peer_taken)
					report_mismatch("peer_taken", 32'(m_tdata[26]), 32'(want.peer_taken));
				if (m_tdata[27] !== want.bad_access)
					report_mismatch("bad_access", 32'(m_tdata[27]), 32'(want.bad_access));
				if (m_tdata[31:28] !== 4'b0)
					report_mismatch("pad", 32'(m_tdata[31:28]), 32'd0);
				n_irq   += 32'(want.irq);
				n_tx    += 32'(want.tx_valid);
				n_taken += 32'(want.peer_taken);
				n_bad   += 32'(want.bad_access);
			end
			n_checked++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d responses still due", cycles,
			         responses_due.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] ctl;
		int pick;
		int steps;

		// ---- directed part ----
		// reset values of every register, then unknown offsets both ways
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_STATUS, '0, 1'b1, 8'hFF, 1'b1);
		// UE off: peer ignored
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_DATA,   '0, 1'b1, 8'hA5, 1'b1);
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_BAUD,   '0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_CTRL1,  '0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_CTRL2,  '0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_CTRL3,  '0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_GUARD,  '0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ,  8'hFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_WRITE, 8'h03, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1);
		// width masks on all-ones writes; control one all ones enables everything
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_BAUD,  32'hFFFF_FFFF,
		             1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_CTRL2, 32'hFFFF_FFFF,
		             1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_CTRL3, 32'hFFFF_FFFF,
		             1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_GUARD, 32'hFFFF_FFFF,
		             1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_CTRL1, 32'hFFFF_FFFF,
		             1'b0, 8'h00, 1'b0);
		// data write sends low byte; peer data raises RXNE
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_DATA,  32'hFFFF_FFFF,
		             1'b1, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ,  uart_rb_pkg::OFF_STATUS, '0, 1'b0, 8'h00, 1'b0);
		// data reads: byte taken with more pending, taken with none, nothing offered
		queue_access(uart_rb_pkg::CMD_READ,  uart_rb_pkg::OFF_DATA, '0, 1'b1, 8'h5A, 1'b1);
		queue_access(uart_rb_pkg::CMD_READ,  uart_rb_pkg::OFF_DATA, '0, 1'b1, 8'hFF, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ,  uart_rb_pkg::OFF_DATA, '0, 1'b0, 8'h00, 1'b1);
		// status write of zero clears every bit, including TXE
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_STATUS, 32'h0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ,  uart_rb_pkg::OFF_STATUS, '0, 1'b0, 8'h00, 1'b0);
		// unknown write, irq check
		queue_access(uart_rb_pkg::CMD_WRITE, 8'h80, 32'h0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_READ,  uart_rb_pkg::OFF_CTRL1, '0, 1'b0, 8'h00, 1'b0);
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_CTRL1, 32'h0, 1'b0, 8'h00, 1'b0);
		// disabled: no transmit
		queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_DATA,  32'h0, 1'b1, 8'h00, 1'b0);

		// ---- random part ----
		// Mostly sessions: program control one (usually with UE/TE/RE on), then a run of
		// data and status traffic; the rest is plain register access and raw noise.
		while (access_queue.size() < RANDOM_ACCESSES + 25) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				ctl = $urandom;
				if ($urandom_range(0, 3) != 0)
					ctl = ctl | (32'd1 << uart_rb_pkg::C1_UE) | (32'd1 << uart_rb_pkg::C1_TE) |
					      (32'd1 << uart_rb_pkg::C1_RE);
				queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_CTRL1, ctl, coin(),
				             8'($urandom), coin());
				steps = $urandom_range(2, 10);
				repeat (steps) begin
					case ($urandom_range(0, 6))
						0, 1: queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_DATA,
						                   $urandom, coin(), 8'($urandom), coin());
						2, 3: queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_DATA,
						                   $urandom, coin(), 8'($urandom), coin());
						4:    queue_access(uart_rb_pkg::CMD_READ, uart_rb_pkg::OFF_STATUS,
						                   $urandom, coin(), 8'($urandom), coin());
						5:    queue_access(uart_rb_pkg::CMD_WRITE, uart_rb_pkg::OFF_STATUS,
						                   $urandom, coin(), 8'($urandom), coin());
						default: queue_access(coin(), any_register(), $urandom, coin(),
						                      8'($urandom), coin());
					endcase
				end
			end else if (pick < 9) begin
				queue_access(coin(), any_register(), $urandom, coin(), 8'($urandom), coin());
			end else begin
				queue_access(coin(), 8'($urandom), $urandom, coin(), 8'($urandom), coin());
			end
		end

		// reset held low, then released once
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (access_queue.size() != 0 || s_tvalid || responses_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d accesses checked in %0d cycles; %0d mismatches", n_checked, cycles,
		         mismatches);
		$display("tb: coverage - %0d transmits, %0d peer bytes taken, %0d irqs, %0d bad offsets",
		         n_tx, n_taken, n_irq, n_bad);
		if (mismatches == 0 && responses_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
